FILE: rtl/sliding_window_median_defines.svh
// Assertion macros shared by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Property must hold at every rising clock edge outside reset.
`define SWM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Expression must never be true outside reset.
`define SWM_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

FILE: rtl/swm_pkg.sv
// Types and constants of the sliding window median filter.
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int CFG_W    = 7;

   // Command codes broadcast to the sorted cell row
   typedef logic [1:0] cell_op_type;
   localparam cell_op_type CELL_HOLD   = 2'd0;
   localparam cell_op_type CELL_INSERT = 2'd1;
   localparam cell_op_type CELL_REMOVE = 2'd2;
   localparam cell_op_type CELL_CLEAR  = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_of_sequence;
   } req_word_type;

   typedef struct packed {
      logic signed [MEDIAN_W-1:0] median_times_two;
   } rsp_word_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_size;
   } csr_word_type;

   // Content of one sorted cell
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                valid;
   } cell_type;

   typedef struct packed {
      cell_op_type         op;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] oldest;
   } cell_cmd_type;

   // Arrival history control
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } hist_ctl_type;

   // Left neighbor of the first cell: valid, most negative value
   localparam cell_type CELL_HEAD  = '{value: {1'b1, {(SAMPLE_W-1){1'b0}}}, valid: 1'b1};
   // Right neighbor of the last cell: empty
   localparam cell_type CELL_EMPTY = '{value: '0, valid: 1'b0};

endpackage

FILE: rtl/swm_channels.sv
// Handshake channel interfaces of the sliding window median filter.
interface swm_req_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface swm_rsp_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface swm_csr_if;
   logic                 valid;
   logic                 ready;
   swm_pkg::csr_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sliding_window_median.sv
// Top level of the sliding window median filter over signed 32-bit samples.
//
// Channels (valid/ready, a word moves when both are high at a rising edge):
//   req_if : sample and last_of_sequence flag in.
//   rsp_if : median_times_two out, twice the median (one fractional bit).
//   csr_if : window_size write, K in 1..WINDOW_MAX (0 acts as 1, larger saturates).
//            Writing it empties the window. Write only while the block is idle.
// A word is taken in one cycle and worked in the next, so a new word is not
// taken before the last one is worked: the sorted cell row inserts, then removes.
// Once K samples are held, each word yields one result, loaded into the output
// register in its work cycle. Fewer than K samples: no result.
// The output register frees the input side: a new word is taken while a result
// still waits. If the receiver stalls and the next word must also deliver,
// the block holds that word in the work cycle until the output is taken.
// last_of_sequence empties the window after its own word is worked.
// Reset (synchronous, active high) empties the window, K returns to 1.
// No clearing pass: the history store is only read where it was written.
module sliding_window_median #(
   parameter int WINDOW_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   swm_req_if.sink     req_if,
   swm_rsp_if.source   rsp_if,
   swm_csr_if.sink     csr_if
);
   import swm_pkg::*;

   `include "sliding_window_median_defines.svh"

   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int KW = $clog2(WINDOW_MAX + 1);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_WORK = 1'b1;

   // control
   logic [0:0]          state_ff;
   logic [0:0]          state_in;
   logic [KW-1:0]       k_ff;
   logic [KW-1:0]       k_in;
   logic [KW-1:0]       k_new;
   logic [IW-1:0]       lo_ff;
   logic [IW-1:0]       lo_in;
   logic [IW-1:0]       hi_ff;
   logic [IW-1:0]       hi_in;
   logic [KW-1:0]       fill_ff;
   logic [KW-1:0]       fill_in;
   logic                last_ff;
   logic                last_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [MEDIAN_W-1:0] out_data_ff;

   logic                req_acc;
   logic                csr_acc;
   logic                full;
   logic                go;
   logic                result_load;

   // cell row
   cell_cmd_type        cell_cmd;
   cell_type            cell_q  [WINDOW_MAX];
   cell_type            left_w  [WINDOW_MAX];
   cell_type            right_w [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] valid_vec;

   hist_ctl_type        hist_ctl;
   logic [SAMPLE_W-1:0] hist_oldest;

   logic [SAMPLE_W-1:0] lo_val;
   logic [SAMPLE_W-1:0] hi_val;
   logic [MEDIAN_W-1:0] median_sum;

   // handshakes: config wins over a sample in the same cycle
   assign csr_if.ready = (state_ff == ST_IDLE);
   assign req_if.ready = (state_ff == ST_IDLE) && !csr_if.valid;
   assign csr_acc      = csr_if.valid && csr_if.ready;
   assign req_acc      = req_if.valid && req_if.ready;

   // window holds K samples after the insert: a result is due
   assign full        = (fill_ff == k_ff);
   // work cycle may finish unless its result meets a full output register
   assign go          = (state_ff == ST_WORK) &&
                        (!full || !out_valid_ff || rsp_if.ready);
   assign result_load = go && full;

   // effective window length and the two middle positions
   always_comb begin
      priority if (csr_if.data.window_size == '0) begin
         k_new = KW'(1);
      end else if (32'(csr_if.data.window_size) > WINDOW_MAX) begin
         k_new = KW'(WINDOW_MAX);
      end else begin
         k_new = KW'(csr_if.data.window_size);
      end
   end

   // lower middle is (K-1)/2, upper middle K/2; equal for odd K
   assign k_in  = csr_acc ? k_new : k_ff;
   assign lo_in = csr_acc ? IW'((k_new - KW'(1)) >> 1) : lo_ff;
   assign hi_in = csr_acc ? IW'(k_new >> 1) : hi_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      last_in  = last_ff;
      priority if (csr_acc) begin
         fill_in = '0;
      end else if (req_acc) begin
         fill_in  = fill_ff + KW'(1);
         last_in  = req_if.data.last_of_sequence;
         state_in = ST_WORK;
      end else if (go) begin
         state_in = ST_IDLE;
         if (last_ff) begin
            fill_in = '0;
         end else if (full) begin
            fill_in = fill_ff - KW'(1);
         end
      end
   end

   // command broadcast to every cell
   always_comb begin
      cell_cmd.op     = CELL_HOLD;
      cell_cmd.sample = req_if.data.sample;
      cell_cmd.oldest = hist_oldest;
      priority if (csr_acc) begin
         cell_cmd.op = CELL_CLEAR;
      end else if (req_acc) begin
         cell_cmd.op = CELL_INSERT;
      end else if (go && last_ff) begin
         cell_cmd.op = CELL_CLEAR;
      end else if (go && full) begin
         cell_cmd.op = CELL_REMOVE;
      end
   end

   assign hist_ctl.push  = req_acc;
   assign hist_ctl.pop   = go && full && !last_ff;
   assign hist_ctl.clear = csr_acc || (go && last_ff);

   swm_history #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_history (
      .clock       (clock),
      .reset       (reset),
      .ctl         (hist_ctl),
      .wr_data     (req_if.data.sample),
      .fill        (fill_ff),
      .oldest_data (hist_oldest)
   );

   // sorted row, ascending from cell 0
   for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_w[g] = CELL_HEAD;
      end else begin : g_link_left
         assign left_w[g] = cell_q[g-1];
      end
      if (g == WINDOW_MAX - 1) begin : g_tail
         assign right_w[g] = CELL_EMPTY;
      end else begin : g_link_right
         assign right_w[g] = cell_q[g+1];
      end

      swm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cell_cmd),
         .left  (left_w[g]),
         .right (right_w[g]),
         .own   (cell_q[g])
      );

      assign valid_vec[g] = cell_q[g].valid;
   end

   // pick the two middle cells
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (lo_ff == IW'(i)) begin
            lo_val = cell_q[i].value;
         end
         if (hi_ff == IW'(i)) begin
            hi_val = cell_q[i].value;
         end
      end
   end

   assign median_sum = {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};

   always_comb begin
      priority if (result_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= KW'(1);
         lo_ff        <= '0;
         hi_ff        <= '0;
         fill_ff      <= '0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         out_data_ff <= median_sum;
      end
   end

   assign rsp_if.valid                 = out_valid_ff;
   assign rsp_if.data.median_times_two = out_data_ff;

   // fill count never passes the window length
   `SWM_ASSERT_NEVER(a_fill_within_k, clock, reset, fill_ff > k_ff, "fill count above window length")
   // occupied cells and fill count agree
   `SWM_ASSERT(a_cells_match_fill, clock, reset, $countones(valid_vec) == 32'(fill_ff), "cell row out of step with fill count")
   // a fresh result comes only from a full window in a work cycle
   `SWM_ASSERT(a_result_from_full, clock, reset, $rose(out_valid_ff) |-> $past(full && state_ff == ST_WORK), "result without a full window")

endmodule

FILE: rtl/swm_cell.sv
// One cell of the sorted window row: holds one sample and trades with its neighbors.
module swm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::cell_cmd_type cmd,
   input  swm_pkg::cell_type     left,
   input  swm_pkg::cell_type     right,
   output swm_pkg::cell_type     own
);
   import swm_pkg::*;

   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] value_in;
   logic                valid_ff;
   logic                valid_in;
   logic                below_left;
   logic                below_self;
   logic                not_below_oldest;

   assign below_left       = $signed(cmd.sample) < $signed(left.value);
   assign below_self       = $signed(cmd.sample) < $signed(value_ff);
   assign not_below_oldest = $signed(value_ff) >= $signed(cmd.oldest);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            // shift up where the new sample sorts below the left entry
            if (left.valid && below_left) begin
               value_in = left.value;
               valid_in = 1'b1;
            end else if (left.valid && (!valid_ff || below_self)) begin
               value_in = cmd.sample;
               valid_in = 1'b1;
            end
         end
         CELL_REMOVE: begin
            // everything from the first copy of the oldest value moves down
            if (valid_ff && not_below_oldest) begin
               value_in = right.value;
               valid_in = right.valid;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign own.value = value_ff;
   assign own.valid = valid_ff;

endmodule

FILE: rtl/swm_history.sv
// Arrival order history: circular sample store that yields the oldest sample.
module swm_history #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  swm_pkg::hist_ctl_type              ctl,
   input  logic [swm_pkg::SAMPLE_W-1:0]       wr_data,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]    fill,
   output logic [swm_pkg::SAMPLE_W-1:0]       oldest_data
);
   import swm_pkg::*;

   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int SW = KW + 1;

   logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
   logic [IW-1:0]       oldest_ff;
   logic [IW-1:0]       oldest_in;
   logic [SW-1:0]       slot_sum;
   logic [SW-1:0]       next_sum;
   logic [IW-1:0]       wr_slot;
   logic [SAMPLE_W-1:0] rd_ff;
   logic [SAMPLE_W-1:0] byp_data_ff;
   logic                bypass_ff;

   assign slot_sum = SW'(oldest_ff) + SW'(fill);
   assign wr_slot  = (slot_sum >= SW'(WINDOW_MAX)) ? IW'(slot_sum - SW'(WINDOW_MAX))
                                                   : IW'(slot_sum);
   assign next_sum = SW'(oldest_ff) + SW'(1);

   always_comb begin
      priority if (ctl.clear) begin
         oldest_in = '0;
      end else if (ctl.pop) begin
         oldest_in = (next_sum >= SW'(WINDOW_MAX)) ? '0 : IW'(next_sum);
      end else begin
         oldest_in = oldest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         bypass_ff <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         // empty store: the slot written now is the oldest one
         bypass_ff <= ctl.push && (fill == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_slot] <= wr_data;
      end
      rd_ff       <= mem[oldest_ff];
      byp_data_ff <= wr_data;
   end

   assign oldest_data = bypass_ff ? byp_data_ff : rd_ff;

endmodule

FILE: test/sliding_window_median_tb.sv
// Self-checking testbench of the sliding window median filter.
`timescale 1ns / 100ps

module sliding_window_median_tb;
   import swm_pkg::*;

   localparam int WINDOW_MAX = 64;
   // Cycles a word may still be in work after the last result came out
   localparam int SETTLE_CYCLES = 4;
   // Receiver hold-off that backs the block up into its input
   localparam int HOLD_CYCLES = 200;
   // Random phases that carry the pressure cases
   localparam int HOLD_PHASE   = 0;
   localparam int PAUSE_PHASE  = 2;
   localparam int STEADY_PHASE = 7;
   localparam int IDLE_PCT = 26;

   localparam logic signed [SAMPLE_W-1:0] SMIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] SMAX = 32'sh7fff_ffff;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // One directed step: a sample word, or a window_size write
   typedef struct packed {
      row_kind_type               kind;
      logic [CFG_W-1:0]           window;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic                       typed;   // median below is the expected result
      logic signed [MEDIAN_W-1:0] median;
   } script_row_type;

   localparam int SCRIPT_LEN = 30;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // K = 1 after reset: each word comes straight back doubled
      '{ROW_WORD, 7'd0,   SMIN,   1'b0, 1'b1, 33'h1_0000_0000},
      '{ROW_WORD, 7'd0,   SMAX,   1'b0, 1'b1, 33'h0_ffff_fffe},
      '{ROW_WORD, 7'd0,   32'sd0, 1'b1, 1'b1, 33'h0_0000_0000},
      // zero window size acts as K = 1
      '{ROW_CSR,  7'd0,   32'sd0, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd5, 1'b0, 1'b1, 33'h0_0000_000a},
      '{ROW_WORD, 7'd0,   -32'sd1, 1'b0, 1'b1, 33'h1_ffff_fffe},
      // K = 2: sums of the extremes
      '{ROW_CSR,  7'd2,   32'sd0, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   SMAX,   1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   SMAX,   1'b0, 1'b1, 33'h0_ffff_fffe},
      '{ROW_WORD, 7'd0,   SMIN,   1'b0, 1'b1, 33'h1_ffff_ffff},
      '{ROW_WORD, 7'd0,   SMIN,   1'b1, 1'b1, 33'h1_0000_0000},
      // K = 3 with equal samples in the window
      '{ROW_CSR,  7'd3,   32'sd0, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd7, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd7, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd7, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd1, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd9, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd7, 1'b1, 1'b0, 33'h0},
      // oversize K saturates to 64: short sequence, no result
      '{ROW_CSR,  7'd127, 32'sd0, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd100, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   -32'sd100, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd3, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd0, 1'b1, 1'b0, 33'h0},
      // K = 4, even window with repeats
      '{ROW_CSR,  7'd4,   32'sd0, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   -32'sd8, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd40, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd40, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   -32'sd8, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   32'sd12, 1'b0, 1'b0, 33'h0},
      '{ROW_WORD, 7'd0,   SMIN,   1'b1, 1'b0, 33'h0}
   };

   logic clock;
   logic reset;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();
   swm_csr_if csr_bus ();

   sliding_window_median #(
      .WINDOW_MAX(WINDOW_MAX)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Predictor state: effective K, samples in arrival order, same samples ranked
   int unsigned span_k = 1;
   int          arrival_q[$];
   int          ranked_q[$];

   // Medians still owed by the block, oldest first
   logic signed [MEDIAN_W-1:0] median_due_q[$];

   int unsigned mismatch_count = 0;
   bit          steady_run = 1'b0;    // no idling on either side
   bit          hold_request = 1'b0;  // asks the receiver for a long hold-off

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[sliding_window_median] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // Zero acts as 1, anything past the store depth saturates
   function automatic int unsigned window_k(input logic [CFG_W-1:0] ws);
      if (ws == 0) return 1;
      if (32'(ws) > WINDOW_MAX) return WINDOW_MAX;
      return 32'(ws);
   endfunction

   // Works one accepted word; returns 1 with the median when the window is full
   function automatic bit predict_word(input req_word_type w,
                                       output logic signed [MEDIAN_W-1:0] median);
      int     pos;
      int     v;
      longint sum;
      bit     has;
      v = w.sample;
      has = 1'b0;
      median = '0;
      if (arrival_q.size() < span_k) begin
         arrival_q = {arrival_q, v};
         // equal entries keep arrival order: new one goes after them
         pos = 0;
         while (pos < ranked_q.size() && ranked_q[pos] <= v) pos++;
         ranked_q.insert(pos, v);
      end
      if (arrival_q.size() >= span_k) begin
         if (span_k % 2)
            sum = 2 * longint'(ranked_q[(span_k - 1) / 2]);
         else
            sum = longint'(ranked_q[span_k / 2 - 1]) + longint'(ranked_q[span_k / 2]);
         median = sum[MEDIAN_W-1:0];
         has = 1'b1;
         // oldest sample leaves: drop one ranked entry of its value
         v = arrival_q.pop_front();
         pos = 0;
         while (ranked_q[pos] != v) pos++;
         ranked_q.delete(pos);
      end
      if (w.last_of_sequence) begin
         arrival_q.delete();
         ranked_q.delete();
      end
      return has;
   endfunction

   // Offers one word, with a random gap ahead of it; valid stays high after
   // acceptance so back-to-back words need no drop in between.
   task automatic send_word(input logic signed [SAMPLE_W-1:0] sample, input logic last,
                            input logic typed, input logic signed [MEDIAN_W-1:0] typed_median);
      req_word_type               w;
      logic signed [MEDIAN_W-1:0] median;
      bit                         has;
      w.sample = sample;
      w.last_of_sequence = last;
      if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      do @(posedge clock); while (!req_bus.ready);
      has = predict_word(w, median);
      if (typed)
         median_due_q = {median_due_q, typed_median};
      else if (has)
         median_due_q = {median_due_q, median};
   endtask

   // Stops offering and waits until every owed median has come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (median_due_q.size() != 0);
   endtask

   // window_size write, only with the block idle; empties the window
   task automatic write_window(input logic [CFG_W-1:0] ws);
      csr_word_type c;
      c.window_size = ws;
      drain_results();
      // a word that gives no result may still be in work
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= c;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      span_k = window_k(ws);
      arrival_q.delete();
      ranked_q.delete();
   endtask

   // Result side: check each accepted word against the oldest owed median,
   // then pick ready for the next cycle (random stalls or a long hold-off)
   initial begin
      int                         hold_left;
      bit                         hold_taken;
      logic signed [MEDIAN_W-1:0] want;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (median_due_q.size() == 0) begin
               report_mismatch($sformatf("unexpected median %0d",
                                         rsp_bus.data.median_times_two));
            end else begin
               want = median_due_q.pop_front();
               if (rsp_bus.data.median_times_two !== want)
                  report_mismatch($sformatf("median_times_two %0d, expected %0d",
                                            rsp_bus.data.median_times_two, want));
            end
         end
         if (hold_request && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Stimulus
   initial begin
      logic [CFG_W-1:0]           phase_sizes[$];
      logic signed [SAMPLE_W-1:0] sample;
      int unsigned                eff_k;
      int unsigned                n_words;
      logic                       last;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR)
            write_window(SCRIPT[i].window);
         else
            send_word(SCRIPT[i].sample, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].median);
      end

      // random part: one phase per window size, extremes and oversize among them
      phase_sizes = '{7'd1, 7'd64, 7'd5, 7'd0, 7'd2, 7'd127, 7'd65, 7'd3, 7'd8, 7'd2, 7'd7};
      phase_sizes = {phase_sizes, 7'($urandom_range(1, WINDOW_MAX))};
      phase_sizes = {phase_sizes, 7'($urandom_range(4, 16))};
      foreach (phase_sizes[p]) begin
         write_window(phase_sizes[p]);
         eff_k = window_k(phase_sizes[p]);
         n_words = (eff_k >= 32) ? 80 : 20 + $urandom_range(10);
         steady_run = (p == STEADY_PHASE);
         for (int n = 0; n < n_words; n++) begin
            if (p == HOLD_PHASE && n == 3) hold_request = 1'b1;
            if (p == PAUSE_PHASE && n == 12) drain_results();
            case ($urandom_range(9))
               0: sample = SMIN;
               1: sample = SMAX;
               2, 3, 4: sample = int'($urandom_range(6)) - 3;   // many equal values
               5: sample = $urandom_range(1) ? SMIN + $urandom_range(3)
                                             : SMAX - $urandom_range(3);
               default: sample = $urandom;
            endcase
            // long windows need long sequences to fill
            last = (eff_k >= 32) ? ($urandom_range(199) == 0) : ($urandom_range(11) == 0);
            send_word(sample, last, 1'b0, '0);
         end
      end
      steady_run = 1'b0;

      drain_results();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[sliding_window_median] OK");
      else
         $display("[sliding_window_median] ERROR");
      $finish;
   end

endmodule

FILE: sliding_window_median.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_channels.sv
rtl/swm_cell.sv
rtl/swm_history.sv
rtl/sliding_window_median.sv
test/sliding_window_median_tb.sv
